[hdl/stbs_pkg.sv]
// Shared types and constants for the sorted table with binary search.
package stbs_pkg;

  localparam int DepthDef    = 1024;
  localparam int WordBitsDef = 32;
  localparam int ValueBits   = 32;
  localparam int PosBits     = 10;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef struct packed {
    logic                        cmd;
    logic signed [ValueBits-1:0] value;
    logic                        last;
  } stbs_in_t;

  typedef struct packed {
    logic               found;
    logic [PosBits-1:0] position;
  } stbs_out_t;

  typedef struct packed {
    logic load;
    logic search;
    logic pass_start;
    logic pass_load;
    logic pass_step;
    logic pass_end;
    logic probe;
    logic compare;
    logic out_load;
  } stbs_cmd_t;

  typedef struct packed {
    logic load_short;
    logic step_last;
    logic pass_more;
    logic probe_empty;
    logic hit;
  } stbs_status_t;

endpackage

[hdl/sorted_table_binary_search.sv]
// Sorted table with binary search: takes load and search beats, sorts after the last load,
// and gives one result beat (found, position) for each search beat.
// Input channel: in_valid_i / in_stall_o carry in_data_i.
// A load beat marked last starts a bubble sort of the filled entries if there are at least two;
// each pass runs PASS_START, PASS_LOAD, a PASS_STEP per compared pair and PASS_END; the sort
// ends after the first pass without a swap or after the pass over the first two entries.
// The table memory has one port for reading and one for writing.
// A search beat probes one entry at a time, each probe going through PROBE and COMPARE, until
// a hit or an empty window; the result then waits in DONE until the output register takes it.
// Output channel: out_valid_o / out_stall_i carry out_data_o. The result
// sits in an output register, so loads are still accepted while a result waits; a
// search that finishes while the receiver stalls holds until the register frees.
// Only one beat is in work at a time; in_stall_o is high while a sort or search runs.
// Reset empties the table (fill count zero) and needs no clearing pass; words of the
// memory are only read after they were written in the current table.
module sorted_table_binary_search #(
  parameter int DEPTH     = stbs_pkg::DepthDef,
  parameter int WORD_BITS = stbs_pkg::WordBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  stbs_pkg::stbs_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output stbs_pkg::stbs_out_t out_data_o
);
  import stbs_pkg::*;

  stbs_cmd_t    cmd;
  stbs_status_t status;

  stbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_data_i.cmd),
    .in_last_i   (in_data_i.last),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  stbs_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

[hdl/stbs_datapath.sv]
// Datapath: table memory, bubble-sort carry register, search window and result registers.
module stbs_datapath #(
  parameter int DEPTH     = stbs_pkg::DepthDef,
  parameter int WORD_BITS = stbs_pkg::WordBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  stbs_pkg::stbs_cmd_t    cmd_i,
  input  stbs_pkg::stbs_in_t     in_data_i,
  output stbs_pkg::stbs_status_t status_o,
  output stbs_pkg::stbs_out_t    out_data_o
);
  import stbs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  logic signed [WORD_BITS-1:0] mem [DEPTH];
  logic signed [WORD_BITS-1:0] rdata_q;
  logic signed [WORD_BITS-1:0] carry_q;
  logic signed [WORD_BITS-1:0] key_q;
  logic [CW-1:0]               fill_q;
  logic                        fresh_q;
  logic [CW-1:0]               idx_q;
  logic [CW-1:0]               limit_q;
  logic                        swapped_q;
  logic [CW-1:0]               lo_q;
  logic [CW-1:0]               hix_q;
  logic [CW-1:0]               mid_q;
  logic                        res_found_q;
  logic [PosBits-1:0]          res_pos_q;
  stbs_out_t                   out_q;

  logic signed [WORD_BITS-1:0] in_word;
  logic [CW-1:0]               base;
  logic                        room;
  logic [CW-1:0]               fill_new;
  logic [CW-1:0]               mid;
  logic                        gt;
  logic                        eq;
  logic                        lt;
  logic                        we;
  logic [AW-1:0]               wa;
  logic signed [WORD_BITS-1:0] wd;
  logic [CW-1:0]               ra;

  // Load words and the search key are wrapped or sign-extended to the stored word width.
  assign in_word  = WORD_BITS'(in_data_i.value);
  assign base     = fresh_q ? '0 : fill_q;
  assign room     = base < DepthC;
  assign fill_new = base + CW'(room);
  // Floor midpoint of the window [lo, hix), valid only when the window is not empty.
  assign mid      = lo_q + ((hix_q - lo_q - CW'(1)) >> 1);
  assign gt       = carry_q > rdata_q;
  assign eq       = rdata_q == key_q;
  assign lt       = rdata_q < key_q;

  assign status_o.load_short  = fill_new < CW'(2);
  assign status_o.step_last   = (idx_q + CW'(1)) == limit_q;
  assign status_o.pass_more   = swapped_q && (limit_q >= CW'(2));
  assign status_o.probe_empty = !(lo_q < hix_q);
  assign status_o.hit         = eq;

  assign out_data_o = out_q;

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = in_word;
    if (cmd_i.load) begin
      we = room;
      wa = base[AW-1:0];
    end else if (cmd_i.pass_step) begin
      we = 1'b1;
      wa = idx_q[AW-1:0];
      wd = gt ? rdata_q : carry_q;
    end else if (cmd_i.pass_end) begin
      we = 1'b1;
      wa = limit_q[AW-1:0];
      wd = carry_q;
    end
  end

  always_comb begin
    ra = '0;
    if (cmd_i.pass_load) begin
      ra = idx_q + CW'(1);
    end else if (cmd_i.pass_step) begin
      ra = idx_q + CW'(2);
    end else if (cmd_i.probe) begin
      ra = mid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_q <= mem[ra[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      fresh_q <= 1'b1;
    end else if (cmd_i.load) begin
      fill_q  <= fill_new;
      fresh_q <= in_data_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      limit_q <= fill_new - CW'(1);
    end
    if (cmd_i.pass_start) begin
      idx_q     <= '0;
      swapped_q <= 1'b0;
    end
    if (cmd_i.pass_load) begin
      carry_q <= rdata_q;
    end
    // The carry holds the largest word seen so far in this pass.
    if (cmd_i.pass_step) begin
      carry_q   <= gt ? carry_q : rdata_q;
      swapped_q <= swapped_q | gt;
      idx_q     <= idx_q + CW'(1);
    end
    if (cmd_i.pass_end) begin
      limit_q <= limit_q - CW'(1);
    end
    if (cmd_i.search) begin
      key_q <= in_word;
      lo_q  <= '0;
      hix_q <= fill_q;
    end
    if (cmd_i.probe) begin
      mid_q <= mid;
      if (status_o.probe_empty) begin
        res_found_q <= 1'b0;
        res_pos_q   <= '0;
      end
    end
    if (cmd_i.compare) begin
      if (eq) begin
        res_found_q <= 1'b1;
        res_pos_q   <= PosBits'(mid_q);
      end else if (lt) begin
        lo_q <= mid_q + CW'(1);
      end else begin
        hix_q <= mid_q;
      end
    end
    if (cmd_i.out_load) begin
      out_q.found    <= res_found_q;
      out_q.position <= res_pos_q;
    end
  end

endmodule

[hdl/stbs_ctrl.sv]
// Controller: sequences loads, sort passes, search probes and the result beat.
module stbs_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_cmd_i,
  input  logic                   in_last_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  stbs_pkg::stbs_status_t status_i,
  output stbs_pkg::stbs_cmd_t    cmd_o
);
  import stbs_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    PASS_START,
    PASS_LOAD,
    PASS_STEP,
    PASS_END,
    PROBE,
    COMPARE,
    DONE
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   accept;

  assign accept      = in_valid_i && (state_q == IDLE);
  assign in_stall_o  = state_q != IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = accept && (in_cmd_i == CMD_LOAD);
    cmd_o.search     = accept && (in_cmd_i == CMD_SEARCH);
    cmd_o.pass_start = state_q == PASS_START;
    cmd_o.pass_load  = state_q == PASS_LOAD;
    cmd_o.pass_step  = state_q == PASS_STEP;
    cmd_o.pass_end   = state_q == PASS_END;
    cmd_o.probe      = state_q == PROBE;
    cmd_o.compare    = state_q == COMPARE;
    cmd_o.out_load   = (state_q == DONE) && (!out_valid_q || !out_stall_i);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      IDLE: begin
        if (cmd_o.load && in_last_i && !status_i.load_short) begin
          state_d = PASS_START;
        end else if (cmd_o.search) begin
          state_d = PROBE;
        end
      end
      PASS_START: state_d = PASS_LOAD;
      PASS_LOAD:  state_d = PASS_STEP;
      PASS_STEP: begin
        if (status_i.step_last) begin
          state_d = PASS_END;
        end
      end
      PASS_END: begin
        state_d = status_i.pass_more ? PASS_START : IDLE;
      end
      PROBE: begin
        state_d = status_i.probe_empty ? DONE : COMPARE;
      end
      COMPARE: begin
        state_d = status_i.hit ? DONE : PROBE;
      end
      DONE: begin
        if (cmd_o.out_load) begin
          state_d = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
